/* hw/rtl/positional_list_engine_top_assert.svh */
// assertion macros for the positional list engine
// used by positional_list_engine_top; expects clk and rst in scope
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// property checked at every clock edge outside reset
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the trigger
`define PLE_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ple_pkg.sv */
// shared types and constants for the positional list engine
// no dependencies; used by ple_cell and positional_list_engine_top
`default_nettype none

package ple_pkg;

  localparam int WORD_BITS        = 32;
  localparam int CAPACITY_DEF     = 16;
  // position and count compare width, enough for the largest capacity of 256
  localparam int CNT_BITS_MAX     = 9;
  localparam int POS_FIELD_BITS   = 5;
  localparam int POS2_FIELD_BITS  = 4;
  localparam int COUNT_FIELD_BITS = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SWAP   = 2'd2,
    REQ_GET    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    req_kind_t                   req_type;
    logic [POS_FIELD_BITS-1:0]   position;
    logic [POS2_FIELD_BITS-1:0]  second_position;
    logic [WORD_BITS-1:0]        entry_word;
  } req_t;

  typedef struct packed {
    status_t                     status;
    logic [WORD_BITS-1:0]        read_word;
    logic [COUNT_FIELD_BITS-1:0] entry_count;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    req_kind_t               kind;
    logic                    commit;
    logic [CNT_BITS_MAX-1:0] p1;
    logic [CNT_BITS_MAX-1:0] p2;
    logic [WORD_BITS-1:0]    word;
    logic [WORD_BITS-1:0]    word_a;
    logic [WORD_BITS-1:0]    word_b;
  } ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/ple_cell.sv */
// one slot of the list: holds a word, shifts with its neighbors,
// and passes the two read buses along the chain; uses ple_pkg
`default_nettype none

module ple_cell (
  input  wire logic                              clk,
  input  wire ple_pkg::ctrl_t                    ctrl,
  input  wire logic [ple_pkg::CNT_BITS_MAX-1:0]  cell_index,
  input  wire logic [ple_pkg::WORD_BITS-1:0]     left_word,
  input  wire logic [ple_pkg::WORD_BITS-1:0]     right_word,
  input  wire logic [ple_pkg::WORD_BITS-1:0]     bus_a_in,
  input  wire logic [ple_pkg::WORD_BITS-1:0]     bus_b_in,
  output logic      [ple_pkg::WORD_BITS-1:0]     slot_word,
  output logic      [ple_pkg::WORD_BITS-1:0]     bus_a_out,
  output logic      [ple_pkg::WORD_BITS-1:0]     bus_b_out
);
  import ple_pkg::*;

  logic [WORD_BITS-1:0] slot;
  logic [WORD_BITS-1:0] slot_next;
  logic                 hit_a;
  logic                 hit_b;

  assign hit_a = (cell_index == ctrl.p1);
  assign hit_b = (cell_index == ctrl.p2);

  // the cell at a selected position puts its word on the bus
  assign bus_a_out = hit_a ? slot : bus_a_in;
  assign bus_b_out = hit_b ? slot : bus_b_in;
  assign slot_word = slot;

  always_comb begin
    slot_next = slot;
    if (ctrl.commit) begin
      unique case (ctrl.kind)
        REQ_INSERT: begin
          if (cell_index > ctrl.p1) begin
            slot_next = left_word;
          end else if (hit_a) begin
            slot_next = ctrl.word;
          end
        end
        REQ_REMOVE: begin
          if (cell_index >= ctrl.p1) begin
            slot_next = right_word;
          end
        end
        REQ_SWAP: begin
          if (hit_a) begin
            slot_next = ctrl.word_b;
          end else if (hit_b) begin
            slot_next = ctrl.word_a;
          end
        end
        default: begin
          slot_next = slot;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/positional_list_engine_top.sv */
// positional list engine: ordered list of words in a chain of slot cells
// uses ple_pkg, ple_cell and positional_list_engine_top_assert.svh
//
// request channel (req, req_valid, req_stall): one word per request carries
// the kind (insert, remove, swap, get), the positions and the insert data.
// response channel (rsp, rsp_valid, rsp_stall): exactly one word per request
// with status, the word removed or read (zero otherwise) and the entry count.
// an accepted request is carried out in that cycle: each affected cell loads
// from its left or right neighbor, the input word or the other swap slot,
// and the read buses run through the chain of cells in that same cycle.
// rsp_valid is registered and rises in the cycle after acceptance; the single
// response register gives one request per cycle while rsp_stall is low.
// req_stall is high only while a response waits and rsp_stall holds it, so
// a new request is taken in the same cycle the waiting response leaves.
// reset clears the entry count and the response valid; slot contents are
// not cleared, since only entries below the count are ever read.
`default_nettype none
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ple_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_stall,
  output ple_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);
  import ple_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     count_next;
  logic [CNT_BITS_MAX-1:0] cnt_ext;
  logic [CNT_BITS_MAX-1:0] cap_ext;
  logic                    accept;
  status_t                 req_status;
  ctrl_t                   ctrl;
  logic [WORD_BITS-1:0]    read_word;

  logic [WORD_BITS-1:0] slot_words [CAPACITY];
  logic [WORD_BITS-1:0] bus_a [CAPACITY+1];
  logic [WORD_BITS-1:0] bus_b [CAPACITY+1];

  assign cnt_ext = CNT_BITS_MAX'(count);
  assign cap_ext = CNT_BITS_MAX'(CAPACITY);

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // range and full checks; range is tested before full
  always_comb begin
    unique case (req.req_type)
      REQ_INSERT: begin
        if (ctrl.p1 > cnt_ext) begin
          req_status = ST_RANGE;
        end else if (cnt_ext >= cap_ext) begin
          req_status = ST_FULL;
        end else begin
          req_status = ST_OK;
        end
      end
      REQ_SWAP: begin
        req_status = ((ctrl.p1 >= cnt_ext) || (ctrl.p2 >= cnt_ext)) ? ST_RANGE : ST_OK;
      end
      default: begin
        req_status = (ctrl.p1 >= cnt_ext) ? ST_RANGE : ST_OK;
      end
    endcase
  end

  assign ctrl.kind   = req.req_type;
  assign ctrl.p1     = CNT_BITS_MAX'(req.position);
  assign ctrl.p2     = CNT_BITS_MAX'(req.second_position);
  assign ctrl.word   = req.entry_word;
  assign ctrl.word_a = bus_a[CAPACITY];
  assign ctrl.word_b = bus_b[CAPACITY];
  assign ctrl.commit = accept && (req_status == ST_OK) && (req.req_type != REQ_GET);

  always_comb begin
    count_next = count;
    if (ctrl.commit) begin
      if (req.req_type == REQ_INSERT) begin
        count_next = count + 1'b1;
      end else if (req.req_type == REQ_REMOVE) begin
        count_next = count - 1'b1;
      end
    end
  end

  assign read_word = ((req_status == ST_OK) &&
                      ((req.req_type == REQ_REMOVE) || (req.req_type == REQ_GET)))
                     ? bus_a[CAPACITY] : '0;

  assign bus_a[0] = '0;
  assign bus_b[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_inner_l
      assign left_word = slot_words[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_r
      assign right_word = slot_words[g+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_index (CNT_BITS_MAX'(g)),
      .left_word  (left_word),
      .right_word (right_word),
      .bus_a_in   (bus_a[g]),
      .bus_b_in   (bus_b[g]),
      .slot_word  (slot_words[g]),
      .bus_a_out  (bus_a[g+1]),
      .bus_b_out  (bus_b[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= req_status;
      rsp.read_word   <= read_word;
      rsp.entry_count <= COUNT_FIELD_BITS'(count_next);
    end
  end

  `PLE_ASSERT(a_count_cap, cnt_ext <= cap_ext, "entry count above capacity")
  `PLE_ASSERT_NEXT(a_insert_grows, ctrl.commit && (req.req_type == REQ_INSERT), count == $past(count) + 1'b1, "insert did not grow count")
  `PLE_ASSERT(a_err_zero, (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.read_word == '0), "error word not zero")
  `PLE_ASSERT_NEXT(a_rsp_count, accept, rsp.entry_count == COUNT_FIELD_BITS'(count), "response count mismatch")

endmodule

`default_nettype wire

/* test/positional_list_engine_top_tb.sv */
// self-checking testbench for positional_list_engine_top: directed edge cases,
// a full store and random insert/remove/swap/get traffic against a predictor
// depends on ple_pkg and the engine rtl only
`default_nettype none

module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;

  logic  clk;
  logic  rst       = 1'b1;
  req_t  req       = '0;
  logic  req_valid = 1'b0;
  logic  req_stall;
  rsp_t  rsp;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;

  positional_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // shadow copy of the list
  logic [WORD_BITS-1:0] list_words [CAPACITY];
  int                   list_count = 0;

  rsp_t predicted_rsp [$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   req_idle_en    = 1'b0;
  bit   rsp_idle_en    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= rsp_idle_en && ($urandom_range(99) < 32);
  end

  function automatic rsp_t apply_list_request(req_t r);
    rsp_t                 res;
    int                   p1;
    int                   p2;
    int                   i;
    logic [WORD_BITS-1:0] held;
    p1 = r.position;
    p2 = r.second_position;
    res.status    = ST_OK;
    res.read_word = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (p1 > list_count) begin
          res.status = ST_RANGE;
        end else if (list_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_count; i > p1; i--) list_words[i] = list_words[i-1];
          list_words[p1] = r.entry_word;
          list_count++;
        end
      end
      REQ_REMOVE: begin
        if (p1 >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_word = list_words[p1];
          for (i = p1; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      REQ_SWAP: begin
        if (p1 >= list_count || p2 >= list_count) begin
          res.status = ST_RANGE;
        end else if (p1 != p2) begin
          held           = list_words[p1];
          list_words[p1] = list_words[p2];
          list_words[p2] = held;
        end
      end
      default: begin
        if (p1 >= list_count) res.status = ST_RANGE;
        else res.read_word = list_words[p1];
      end
    endcase
    res.entry_count = list_count[COUNT_FIELD_BITS-1:0];
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(req_kind_t kind, int p1, int p2, logic [WORD_BITS-1:0] word);
    req_t r;
    r.req_type        = kind;
    r.position        = p1[POS_FIELD_BITS-1:0];
    r.second_position = p2[POS2_FIELD_BITS-1:0];
    r.entry_word      = word;
    if (req_idle_en && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 32) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted_rsp.push_back(apply_list_request(r));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (predicted_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response word: status %0d word %h count %0d",
                   rsp.status, rsp.read_word, rsp.entry_count);
      end else begin
        want = predicted_rsp.pop_front();
        if (rsp.status !== want.status || rsp.read_word !== want.read_word ||
            rsp.entry_count !== want.entry_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d word %h count %0d, got status %0d word %h count %0d",
                     want.status, want.read_word, want.entry_count,
                     rsp.status, rsp.read_word, rsp.entry_count);
        end
      end
    end
  end

  task automatic test_empty_and_small_list();
    send_request(REQ_GET,    0,  0, 32'h0);
    send_request(REQ_REMOVE, 31, 0, 32'h0);
    send_request(REQ_SWAP,   0,  0, 32'h0);
    send_request(REQ_INSERT, 1,  0, 32'h1234_5678);  // past the end
    send_request(REQ_INSERT, 0,  0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 1,  0, 32'h0000_0000);  // append
    send_request(REQ_INSERT, 0,  0, 32'hA5A5_5A5A);  // front
    send_request(REQ_INSERT, 1,  0, 32'h5A5A_A5A5);  // middle
    send_request(REQ_GET,    3,  0, 32'h0);
    send_request(REQ_GET,    4,  0, 32'h0);
    send_request(REQ_SWAP,   0,  3, 32'h0);
    send_request(REQ_SWAP,   2,  2, 32'h0);          // same slot
    send_request(REQ_SWAP,   1,  15, 32'h0);         // second position bad
    send_request(REQ_SWAP,   16, 1, 32'h0);          // first position bad
    send_request(REQ_REMOVE, 3,  0, 32'h0);          // last
    send_request(REQ_REMOVE, 0,  0, 32'h0);          // first
    send_request(REQ_GET,    0,  0, 32'h0);
    send_request(REQ_GET,    1,  0, 32'h0);
  endtask

  task automatic test_full_store();
    while (list_count < CAPACITY)
      send_request(REQ_INSERT, $urandom_range(list_count), 0, $urandom);
    send_request(REQ_INSERT, CAPACITY,     0,  32'hDEAD_BEEF);  // full
    send_request(REQ_INSERT, 0,            0,  32'hDEAD_BEEF);  // full
    send_request(REQ_INSERT, CAPACITY + 1, 0,  32'hDEAD_BEEF);  // range wins
    send_request(REQ_GET,    CAPACITY - 1, 0,  32'h0);
    send_request(REQ_SWAP,   0,  CAPACITY - 1, 32'h0);
    send_request(REQ_GET,    CAPACITY,     0,  32'h0);
    send_request(REQ_REMOVE, CAPACITY - 1, 0,  32'h0);
    send_request(REQ_REMOVE, 0,            0,  32'h0);
  endtask

  // each block of 40 items picks a growing, shrinking or balanced mix at random
  task automatic test_random_traffic(int items);
    int                   insert_pct;
    int                   p1;
    int                   p2;
    req_kind_t            kind;
    logic [WORD_BITS-1:0] word;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 65;
          1:       insert_pct = 15;
          default: insert_pct = 35;
        endcase
      end
      if ($urandom_range(99) < insert_pct) begin
        kind = REQ_INSERT;
      end else begin
        case ($urandom_range(2))
          0:       kind = REQ_REMOVE;
          1:       kind = REQ_SWAP;
          default: kind = REQ_GET;
        endcase
      end
      if ($urandom_range(99) < 12) p1 = $urandom_range(31);
      else if (kind == REQ_INSERT) p1 = $urandom_range(list_count);
      else p1 = (list_count == 0) ? 0 : $urandom_range(list_count - 1);
      if (list_count > 0 && $urandom_range(99) < 85) p2 = $urandom_range(list_count - 1);
      else p2 = $urandom_range(15);
      case ($urandom_range(19))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      send_request(kind, p1, p2, word);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_and_small_list();
    req_idle_en = 1'b1;
    rsp_idle_en = 1'b1;
    test_full_store();
    test_random_traffic(900);
    // back-to-back stretch
    req_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    test_random_traffic(400);
    req_idle_en = 1'b1;
    rsp_idle_en = 1'b1;
    test_random_traffic(700);
    req_valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_top.sv
test/positional_list_engine_top_tb.sv
